[rtl/dvd_pkg.sv]
// Shared types and constants for the distance to vibration duty block.
// Used by dvd_div and distance_to_vibration_duty; depends on nothing.
package dvd_pkg;

	// Field widths fixed by the interface
	localparam int DIST_W = 16;
	localparam int DUTY_W = 8;
	localparam int MODE_W = 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Mode codes
	localparam mode_t MODE_BLOCK_AVG = 2'd0;
	localparam mode_t MODE_BLOCK_MIN = 2'd1;
	localparam mode_t MODE_GROW_AVG  = 2'd2;

	// Register byte addresses
	localparam addr_t ADDR_MODE = 4'h0;
	localparam addr_t ADDR_NEAR = 4'h4;
	localparam addr_t ADDR_FAR  = 4'h8;

	// Register reset values
	localparam mode_t RST_MODE = MODE_BLOCK_AVG;
	localparam dist_t RST_NEAR = 16'd300;
	localparam dist_t RST_FAR  = 16'd3000;

	// Empty minimum
	localparam dist_t MIN_EMPTY = 16'hFFFF;

	// Full duty
	localparam duty_t DUTY_MAX = 8'd255;

endpackage

[rtl/dvd_div.sv]
// Restoring divider for the duty quotient, one compare and subtract per cycle.
// Depends on dvd_pkg for the duty width and full-duty constant.
module dvd_div #(
	parameter int DEN_W = 23
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [DEN_W+dvd_pkg::DUTY_W-1:0]       num,
	input  logic [DEN_W-1:0]                       den,
	output logic                                   done,
	output dvd_pkg::duty_t                         quo
);

	localparam int W     = DEN_W + dvd_pkg::DUTY_W;
	localparam int STEP_W = $clog2(dvd_pkg::DUTY_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      dsh_q;
	dvd_pkg::duty_t    quo_q;
	logic              ge;
	logic [W-1:0]      diff;

	// Shared compare and subtract
	assign ge   = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	// Control: top step checks for overflow, then one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(dvd_pkg::DUTY_W);
			end else if (busy_q) begin
				if (step_q == STEP_W'(dvd_pkg::DUTY_W) && ge) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, shifted divisor and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {dvd_pkg::DUTY_W{1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(dvd_pkg::DUTY_W)) begin
				// Quotient would exceed full duty: clamp
				if (ge)
					quo_q <= dvd_pkg::DUTY_MAX;
			end else if (ge) begin
				rem_q <= diff;
				quo_q[step_q[STEP_W-2:0]] <= 1'b1;
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/distance_to_vibration_duty.sv]
// Top level: batch accumulation, APB registers, duty sequencer and output register.
// Depends on dvd_pkg and dvd_div.
//
// Channel   Handshake              Payload
// -------   ---------------------  -----------------------------
// in        in_valid / in_ready    sample_distance[15:0]
// out       out_valid / out_ready  motor_on, duty[7:0]
// cfg       APB psel/penable       paddr[3:0], pwdata, prdata
//
// A sample that gives no result leaves the block ready at once. A sample with a result
// occupies the block through a multiply, a prepare step and up to 9 steps of the shared
// compare-subtract divider.
// Reset clears the batch and loads mode 0, near 300, far 3000; no clearing pass.
// A waiting result sits in the output register while the next sample is taken; a second
// result stalls the sequencer until the first is taken.
module distance_to_vibration_duty #(
	parameter int BUFFER_DEPTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dvd_pkg::dist_t         sample_distance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   motor_on,
	output dvd_pkg::duty_t         duty,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  dvd_pkg::addr_t         paddr,
	input  logic [dvd_pkg::DATA_W-1:0] pwdata,
	output logic [dvd_pkg::DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int SUM_W = dvd_pkg::DIST_W + CNT_W;
	localparam int NUM_W = SUM_W + dvd_pkg::DUTY_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_RES  = 3'd4;

	// Registers
	dvd_pkg::mode_t   mode_q;
	dvd_pkg::dist_t   near_q;
	dvd_pkg::dist_t   far_q;

	// Batch state
	logic [SUM_W-1:0] batch_sum_q;
	dvd_pkg::dist_t   batch_min_q;
	logic             min_valid_q;
	logic [CNT_W-1:0] batch_count_q;

	// Sequencer
	logic [2:0]       state_q;
	logic [SUM_W-1:0] num_q;
	logic [CNT_W-1:0] den_q;
	logic             off_q;
	logic [SUM_W-1:0] fs_q;
	logic             res_on_q;
	dvd_pkg::duty_t   res_duty_q;

	// Output register
	logic             out_valid_q;
	logic             motor_on_q;
	dvd_pkg::duty_t   duty_q;

	logic             in_acc;
	logic             cfg_wr;
	logic [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic             full;
	logic             upd_min;
	dvd_pkg::dist_t   min_nx;
	logic             emit;
	logic             is_min_mode;
	logic [SUM_W-1:0] diff_fs;
	logic [NUM_W-1:0] div_num;
	logic [SUM_W-1:0] div_den;
	logic             div_start;
	logic             div_done;
	dvd_pkg::duty_t   div_quo;
	logic             out_free;

	assign in_ready = state_q == ST_IDLE;
	assign in_acc   = in_valid && in_ready;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	// Next batch values for an accepted sample
	assign sum_nx      = batch_sum_q + SUM_W'(sample_distance);
	assign cnt_nx      = batch_count_q + 1'b1;
	assign full        = cnt_nx == CNT_W'(BUFFER_DEPTH);
	assign upd_min     = sample_distance >= near_q
		&& (!min_valid_q || sample_distance < batch_min_q);
	assign min_nx      = upd_min ? sample_distance : batch_min_q;
	assign is_min_mode = mode_q == dvd_pkg::MODE_BLOCK_MIN;
	assign emit        = full || mode_q == dvd_pkg::MODE_GROW_AVG;

	// Scaled distance gap times 255, and scaled span
	assign diff_fs   = fs_q - num_q;
	assign div_num   = {diff_fs, {dvd_pkg::DUTY_W{1'b0}}} - NUM_W'(diff_fs);
	assign div_den   = SUM_W'(far_q - near_q) * SUM_W'(den_q);
	assign div_start = state_q == ST_PREP && !off_q && num_q < fs_q && far_q > near_q;

	dvd_div #(
		.DEN_W (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dvd_pkg::RST_MODE;
			near_q <= dvd_pkg::RST_NEAR;
			far_q  <= dvd_pkg::RST_FAR;
		end else if (cfg_wr) begin
			unique case (paddr)
				dvd_pkg::ADDR_MODE: mode_q <= pwdata[dvd_pkg::MODE_W-1:0];
				dvd_pkg::ADDR_NEAR: near_q <= pwdata[dvd_pkg::DIST_W-1:0];
				dvd_pkg::ADDR_FAR:  far_q  <= pwdata[dvd_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr)
			dvd_pkg::ADDR_MODE: prdata = dvd_pkg::DATA_W'(mode_q);
			dvd_pkg::ADDR_NEAR: prdata = dvd_pkg::DATA_W'(near_q);
			dvd_pkg::ADDR_FAR:  prdata = dvd_pkg::DATA_W'(far_q);
			default:            prdata = '0;
		endcase
	end

	// Accumulate the batch, clear it when full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_sum_q   <= '0;
			batch_min_q   <= dvd_pkg::MIN_EMPTY;
			min_valid_q   <= 1'b0;
			batch_count_q <= '0;
		end else if (in_acc) begin
			if (full) begin
				batch_sum_q   <= '0;
				batch_min_q   <= dvd_pkg::MIN_EMPTY;
				min_valid_q   <= 1'b0;
				batch_count_q <= '0;
			end else begin
				batch_sum_q   <= sum_nx;
				batch_min_q   <= min_nx;
				min_valid_q   <= min_valid_q || upd_min;
				batch_count_q <= cnt_nx;
			end
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc && emit) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_PREP;
				ST_PREP: state_q <= div_start ? ST_DIV : ST_RES;
				ST_DIV:  if (div_done) state_q <= ST_RES;
				ST_RES:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sequencer datapath: capture operands, scale far limit, pick result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (is_min_mode) begin
				num_q <= SUM_W'(min_nx);
				den_q <= CNT_W'(1);
				off_q <= !(min_valid_q || upd_min);
			end else begin
				num_q <= sum_nx;
				den_q <= cnt_nx;
				off_q <= 1'b0;
			end
		end
		if (state_q == ST_MUL)
			fs_q <= SUM_W'(far_q) * SUM_W'(den_q);
		if (state_q == ST_PREP && !div_start) begin
			if (off_q || num_q >= fs_q) begin
				res_on_q   <= 1'b0;
				res_duty_q <= '0;
			end else begin
				res_on_q   <= 1'b1;
				res_duty_q <= dvd_pkg::DUTY_MAX;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			res_on_q   <= div_quo != '0;
			res_duty_q <= div_quo;
		end
	end

	// Output register: load a finished result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RES && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RES && out_free) begin
			motor_on_q <= res_on_q;
			duty_q     <= res_duty_q;
		end
	end

	assign out_valid = out_valid_q;
	assign motor_on  = motor_on_q;
	assign duty      = duty_q;

endmodule
